/* sv/ols_pkg.sv */
// ----------------------------------------------------------------------------
// ols_pkg
// shared types and constants for the ordered list store
// ----------------------------------------------------------------------------
package ols_pkg;

   localparam int CAPACITY = 32;
   localparam int DATA_W   = 32;
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_END   = 3'd1,
      CMD_PUSH_AFTER = 3'd2,
      CMD_POP_FRONT  = 3'd3,
      CMD_POP_END    = 3'd4,
      CMD_POP_KEY    = 3'd5,
      CMD_LIST_ALL   = 3'd6
   } cmd_type;

   // unused command code, ignored by the store
   localparam logic [CMD_W-1:0] CMD_RESERVED = 3'd7;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK     = 2'd0,
      STATUS_EMPTY  = 2'd1,
      STATUS_FULL   = 2'd2,
      STATUS_NO_KEY = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      CELL_HOLD,
      CELL_PUSH_FRONT,
      CELL_PUSH_END,
      CELL_PUSH_AFTER,
      CELL_POP_FRONT,
      CELL_POP_END,
      CELL_POP_KEY,
      CELL_MARK,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type       op;
      logic [DATA_W-1:0] data;
      logic [DATA_W-1:0] key;
   } cell_ctl_type;

endpackage

/* sv/ols_cell.sv */
// ----------------------------------------------------------------------------
// ols_cell
// one list position: value, occupied bit and end tag, shifts with neighbors
// ----------------------------------------------------------------------------
module ols_cell
   import ols_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cell_ctl_type      ctl,
   input  logic [DATA_W-1:0] left_value,
   input  logic              left_occ,
   input  logic              left_found,
   input  logic              left_first,
   input  logic [DATA_W-1:0] right_value,
   input  logic              right_occ,
   input  logic              right_tag,
   input  logic [DATA_W-1:0] head_value,
   input  logic              head_tag,
   output logic [DATA_W-1:0] value,
   output logic              occ,
   output logic              tag,
   output logic              found,
   output logic              first,
   output logic              is_end
);

   logic [DATA_W-1:0] value_ff, value_in;
   logic              occ_ff, occ_in;
   logic              tag_ff, tag_in;
   logic              match;

   assign match  = occ_ff && (value_ff == ctl.key);
   assign found  = left_found || match;
   assign first  = match && !left_found;
   assign is_end = occ_ff && !right_occ;

   always_comb begin
      value_in = value_ff;
      occ_in   = occ_ff;
      tag_in   = tag_ff;
      case (ctl.op)
         CELL_PUSH_FRONT: begin
            value_in = left_value;
            occ_in   = left_occ;
         end
         CELL_PUSH_END: begin
            if (!occ_ff && left_occ) begin
               value_in = ctl.data;
               occ_in   = 1'b1;
            end
         end
         CELL_PUSH_AFTER: begin
            if (left_found) begin
               value_in = left_first ? ctl.data : left_value;
               occ_in   = left_occ;
            end
         end
         CELL_POP_FRONT: begin
            value_in = right_value;
            occ_in   = right_occ;
         end
         CELL_POP_END: begin
            if (is_end) begin
               occ_in = 1'b0;
            end
         end
         CELL_POP_KEY: begin
            if (found) begin
               value_in = right_value;
               occ_in   = right_occ;
            end
         end
         CELL_MARK: begin
            tag_in = is_end;
         end
         CELL_ROTATE: begin
            value_in = is_end ? head_value : right_value;
            tag_in   = is_end ? head_tag : right_tag;
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         occ_ff <= 1'b0;
         tag_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
         tag_ff <= tag_in;
      end
   end

   assign value = value_ff;
   assign occ   = occ_ff;
   assign tag   = tag_ff;

endmodule

/* sv/ordered_list_store.sv */
// ----------------------------------------------------------------------------
// ordered_list_store
// ordered list of signed values held in a row of shifting cells
// ----------------------------------------------------------------------------
// Every edit command (insert front, end or after a key, delete front, end or
// key) completes in the cycle it is accepted and returns one transaction;
// the whole row of CAPACITY cells shifts in parallel and the key search is a
// match chain running along the cells. List-all tags the end entry at the
// edge it is accepted and then, whenever the result register is empty or
// being emptied, streams one entry per cycle by rotating the row through the
// head cell; req_ready stays low until the tagged end entry has been sent.
// A single output register sits on the result side; a new command is taken
// when no list is streaming and that register is empty or being emptied.
module ordered_list_store
   import ols_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic signed [DATA_W-1:0] req_data_value,
   input  logic signed [DATA_W-1:0] req_match_key,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic signed [DATA_W-1:0] rsp_out_value,
   output logic                rsp_last
);

   typedef enum logic {
      STATE_IDLE,
      STATE_LIST
   } state_type;

   state_type         state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_last_ff, rsp_last_in;

   cell_ctl_type      ctl;
   logic [DATA_W-1:0] cell_value [CAPACITY];
   logic              cell_occ   [CAPACITY];
   logic              cell_tag   [CAPACITY];
   logic              cell_found [CAPACITY];
   logic              cell_first [CAPACITY];
   logic              cell_end   [CAPACITY];

   logic              out_free;
   logic              accept;
   logic              list_empty;
   logic              list_full;
   logic              key_found;
   logic [DATA_W-1:0] end_value;
   logic [DATA_W-1:0] key_value;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_value, right_value;
      logic              left_occ, left_found, left_first;
      logic              right_occ, right_tag;

      if (i == 0) begin : g_head
         assign left_value = ctl.data;
         assign left_occ   = 1'b1;
         assign left_found = 1'b0;
         assign left_first = 1'b0;
      end else begin : g_body
         assign left_value = cell_value[i-1];
         assign left_occ   = cell_occ[i-1];
         assign left_found = cell_found[i-1];
         assign left_first = cell_first[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_value = '0;
         assign right_occ   = 1'b0;
         assign right_tag   = 1'b0;
      end else begin : g_inner
         assign right_value = cell_value[i+1];
         assign right_occ   = cell_occ[i+1];
         assign right_tag   = cell_tag[i+1];
      end

      ols_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_value  (left_value),
         .left_occ    (left_occ),
         .left_found  (left_found),
         .left_first  (left_first),
         .right_value (right_value),
         .right_occ   (right_occ),
         .right_tag   (right_tag),
         .head_value  (cell_value[0]),
         .head_tag    (cell_tag[0]),
         .value       (cell_value[i]),
         .occ         (cell_occ[i]),
         .tag         (cell_tag[i]),
         .found       (cell_found[i]),
         .first       (cell_first[i]),
         .is_end      (cell_end[i])
      );
   end

   assign list_empty = !cell_occ[0];
   assign list_full  = cell_occ[CAPACITY-1];
   assign key_found  = cell_found[CAPACITY-1];

   always_comb begin
      end_value = '0;
      key_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         end_value = end_value | (cell_end[i] ? cell_value[i] : '0);
         key_value = key_value | (cell_first[i] ? cell_value[i] : '0);
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == STATE_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      ctl.op        = CELL_HOLD;
      ctl.data      = req_data_value;
      ctl.key       = req_match_key;

      case (state_ff)
         STATE_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_value_in  = '0;
               rsp_last_in   = 1'b1;
               case (cmd_type'(req_cmd))
                  CMD_PUSH_FRONT: begin
                     if (list_full) rsp_status_in = STATUS_FULL;
                     else ctl.op = CELL_PUSH_FRONT;
                  end
                  CMD_PUSH_END: begin
                     if (list_full) rsp_status_in = STATUS_FULL;
                     else ctl.op = CELL_PUSH_END;
                  end
                  CMD_PUSH_AFTER: begin
                     if (list_empty) rsp_status_in = STATUS_EMPTY;
                     else if (list_full) rsp_status_in = STATUS_FULL;
                     else if (!key_found) rsp_status_in = STATUS_NO_KEY;
                     else ctl.op = CELL_PUSH_AFTER;
                  end
                  CMD_POP_FRONT: begin
                     if (list_empty) rsp_status_in = STATUS_EMPTY;
                     else begin
                        rsp_value_in = cell_value[0];
                        ctl.op       = CELL_POP_FRONT;
                     end
                  end
                  CMD_POP_END: begin
                     if (list_empty) rsp_status_in = STATUS_EMPTY;
                     else begin
                        rsp_value_in = end_value;
                        ctl.op       = CELL_POP_END;
                     end
                  end
                  CMD_POP_KEY: begin
                     if (list_empty) rsp_status_in = STATUS_EMPTY;
                     else if (!key_found) rsp_status_in = STATUS_NO_KEY;
                     else begin
                        rsp_value_in = key_value;
                        ctl.op       = CELL_POP_KEY;
                     end
                  end
                  CMD_LIST_ALL: begin
                     if (list_empty) rsp_status_in = STATUS_EMPTY;
                     else begin
                        // tag the end entry, stream from next cycle
                        rsp_valid_in = 1'b0;
                        ctl.op       = CELL_MARK;
                        state_in     = STATE_LIST;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
            end
         end
         STATE_LIST: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_value_in  = cell_value[0];
               rsp_last_in   = cell_tag[0];
               ctl.op        = CELL_ROTATE;
               if (cell_tag[0]) state_in = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
      if (reset) begin
         state_ff     <= STATE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

/* sv/ols_checker.sv */
// ----------------------------------------------------------------------------
// ols_checker
// port-level checks on the ordered list store, bound to the top level
// ----------------------------------------------------------------------------
module ols_checker
   import ols_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic [CMD_W-1:0]    req_cmd,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [DATA_W-1:0]   rsp_out_value,
   input logic                rsp_last
);

   // a stalled result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_out_value) && $stable(rsp_last))
      else $error("rsp transaction changed while stalled");

   // no new command while the result register stays full
   a_ready_room: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid || rsp_ready)
      else $error("req_ready while result register blocked");

   // an error result is a single final transaction with zero value
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> rsp_last && (rsp_out_value == '0))
      else $error("error result not final or value nonzero");

   // an accepted edit command answers in the next cycle
   a_edit_answer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd != CMD_LIST_ALL) && (req_cmd != CMD_RESERVED)
         |=> rsp_valid && rsp_last)
      else $error("edit command gave no single result");

endmodule

bind ordered_list_store ols_checker u_ols_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_cmd       (req_cmd),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_status    (rsp_status),
   .rsp_out_value (rsp_out_value),
   .rsp_last      (rsp_last)
);

/* bench/tb_ordered_list_store.sv */
// ----------------------------------------------------------------------------
// tb_ordered_list_store
// self-checking bench for the ordered list store
// ----------------------------------------------------------------------------
// A behavioral copy of the list, kept as a queue, predicts every response
// transaction when a command is accepted. A checker compares each response,
// field by field, with the oldest prediction. Named tests cover the empty
// list, basic edits with extreme values, a completely full list, and a long
// random mix. Both channels idle and stall at random.
module tb_ordered_list_store;
   import ols_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      status_type        status;
      logic [DATA_W-1:0] value;
      logic              last;
   } list_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [CMD_W-1:0]          req_cmd = CMD_LIST_ALL;
   logic signed [DATA_W-1:0]  req_data_value = '0;
   logic signed [DATA_W-1:0]  req_match_key = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [STATUS_W-1:0]       rsp_status;
   logic signed [DATA_W-1:0]  rsp_out_value;
   logic                      rsp_last;

   logic [DATA_W-1:0] list_model[$];
   list_result_type   pending_results[$];
   int unsigned       error_count = 0;
   int unsigned       rsp_stall_left = 0;
   bit                idle_enable = 1'b1;

   ordered_list_store DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_data_value (req_data_value),
      .req_match_key  (req_match_key),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_out_value  (rsp_out_value),
      .rsp_last       (rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #10ms;
      $display("tb_ordered_list_store: errors");
      $finish;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 40) begin
         $display("%0t ns: %s", $realtime, what);
      end
   endtask

   // mostly short, a few long
   function automatic int unsigned idle_cycles();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [DATA_W-1:0] rand_value();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               default: return 32'hffff_ffff;
            endcase
         end
         1, 2, 3: return DATA_W'($signed($urandom_range(0, 8)) - 4);
         default: return $urandom;
      endcase
   endfunction

   function automatic int find_key(input logic [DATA_W-1:0] key);
      for (int i = 0; i < list_model.size(); i++) begin
         if (list_model[i] == key) return i;
      end
      return -1;
   endfunction

   function automatic logic [DATA_W-1:0] absent_key();
      logic [DATA_W-1:0] key;
      do key = $urandom; while (find_key(key) >= 0);
      return key;
   endfunction

   function automatic logic [DATA_W-1:0] present_key();
      if (list_model.size() == 0) return rand_value();
      return list_model[$urandom_range(0, list_model.size() - 1)];
   endfunction

   function automatic cmd_type pick_insert();
      case ($urandom_range(0, 2))
         0: return CMD_PUSH_FRONT;
         1: return CMD_PUSH_END;
         default: return CMD_PUSH_AFTER;
      endcase
   endfunction

   function automatic cmd_type pick_delete();
      case ($urandom_range(0, 2))
         0: return CMD_POP_FRONT;
         1: return CMD_POP_END;
         default: return CMD_POP_KEY;
      endcase
   endfunction

   task automatic push_result(input status_type status, input logic [DATA_W-1:0] value,
                              input logic last);
      list_result_type r;
      r.status = status;
      r.value  = value;
      r.last   = last;
      pending_results.push_back(r);
   endtask

   // updates the list copy and queues the responses of one command
   task automatic model_list_command(input logic [CMD_W-1:0] cmd,
                                     input logic [DATA_W-1:0] value,
                                     input logic [DATA_W-1:0] key);
      int pos;
      logic [DATA_W-1:0] removed;
      case (cmd)
         CMD_PUSH_FRONT, CMD_PUSH_END: begin
            if (list_model.size() >= CAPACITY) begin
               push_result(STATUS_FULL, '0, 1'b1);
            end else begin
               if (cmd == CMD_PUSH_FRONT) list_model.push_front(value);
               else list_model.push_back(value);
               push_result(STATUS_OK, '0, 1'b1);
            end
         end
         CMD_PUSH_AFTER: begin
            pos = find_key(key);
            if (list_model.size() == 0) begin
               push_result(STATUS_EMPTY, '0, 1'b1);
            end else if (list_model.size() >= CAPACITY) begin
               push_result(STATUS_FULL, '0, 1'b1);
            end else if (pos < 0) begin
               push_result(STATUS_NO_KEY, '0, 1'b1);
            end else begin
               if (pos + 1 == list_model.size()) list_model.push_back(value);
               else list_model.insert(pos + 1, value);
               push_result(STATUS_OK, '0, 1'b1);
            end
         end
         CMD_POP_FRONT, CMD_POP_END: begin
            if (list_model.size() == 0) begin
               push_result(STATUS_EMPTY, '0, 1'b1);
            end else begin
               if (cmd == CMD_POP_FRONT) removed = list_model.pop_front();
               else removed = list_model.pop_back();
               push_result(STATUS_OK, removed, 1'b1);
            end
         end
         CMD_POP_KEY: begin
            pos = find_key(key);
            if (list_model.size() == 0) begin
               push_result(STATUS_EMPTY, '0, 1'b1);
            end else if (pos < 0) begin
               push_result(STATUS_NO_KEY, '0, 1'b1);
            end else begin
               removed = list_model[pos];
               list_model.delete(pos);
               push_result(STATUS_OK, removed, 1'b1);
            end
         end
         CMD_LIST_ALL: begin
            if (list_model.size() == 0) begin
               push_result(STATUS_EMPTY, '0, 1'b1);
            end else begin
               for (int i = 0; i < list_model.size(); i++) begin
                  push_result(STATUS_OK, list_model[i], i == list_model.size() - 1);
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value,
                           input logic [DATA_W-1:0] key);
      int unsigned gap;
      gap = idle_enable ? idle_cycles() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_data_value <= value;
      req_match_key  <= key;
      do @(posedge clock); while (!req_ready);
      model_list_command(cmd, value, key);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // response side stalls
   always @(posedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 99) < 20) begin
         rsp_stall_left <= idle_cycles();
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : rsp_check
      list_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("response with nothing pending: status %0d value %0d",
                                      rsp_status, rsp_out_value));
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, predicted %0d", rsp_status, want.status));
            if (rsp_out_value !== want.value)
               report_mismatch($sformatf("out_value %0d, predicted %0d",
                                         rsp_out_value, $signed(want.value)));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %0b, predicted %0b", rsp_last, want.last));
         end
      end
   end

   task automatic test_empty_list();
      send_cmd(CMD_LIST_ALL, '0, '0);
      send_cmd(CMD_POP_FRONT, '0, '0);
      send_cmd(CMD_POP_END, '0, '0);
      send_cmd(CMD_POP_KEY, '0, 32'hffff_ffff);
      send_cmd(CMD_PUSH_AFTER, 32'h1234_5678, '0);
      send_cmd(CMD_RESERVED, 32'h7fff_ffff, 32'h8000_0000);
   endtask

   task automatic test_basic_edits();
      send_cmd(CMD_PUSH_FRONT, 32'h7fff_ffff, '0);
      send_cmd(CMD_PUSH_END, 32'h8000_0000, '0);
      send_cmd(CMD_PUSH_FRONT, 32'h0000_0000, '0);
      send_cmd(CMD_PUSH_AFTER, 32'hffff_ffff, 32'h0000_0000);
      send_cmd(CMD_PUSH_AFTER, 32'h0000_0005, 32'h8000_0000);
      send_cmd(CMD_PUSH_AFTER, 32'h0000_0009, 32'h0000_0077);
      send_cmd(CMD_POP_KEY, '0, 32'h0000_0077);
      send_cmd(CMD_LIST_ALL, '0, '0);
      send_cmd(CMD_RESERVED, 32'hffff_ffff, 32'hffff_ffff);
      // duplicates: searches stop at the first match
      send_cmd(CMD_PUSH_END, 32'h0000_0005, '0);
      send_cmd(CMD_PUSH_AFTER, 32'h0000_0009, 32'h0000_0005);
      send_cmd(CMD_POP_KEY, '0, 32'h0000_0005);
      send_cmd(CMD_LIST_ALL, '0, '0);
      send_cmd(CMD_POP_KEY, '0, 32'h7fff_ffff);
      send_cmd(CMD_POP_FRONT, '0, '0);
      send_cmd(CMD_POP_END, '0, '0);
      send_cmd(CMD_POP_KEY, '0, 32'hffff_ffff);
      send_cmd(CMD_POP_END, '0, '0);
      send_cmd(CMD_POP_FRONT, '0, '0);
      send_cmd(CMD_LIST_ALL, '0, '0);
      wait_for_drain();
   endtask

   task automatic test_full_list();
      while (list_model.size() < CAPACITY) begin
         send_cmd(pick_insert(), rand_value(), present_key());
      end
      send_cmd(CMD_PUSH_FRONT, rand_value(), '0);
      send_cmd(CMD_PUSH_END, rand_value(), '0);
      send_cmd(CMD_PUSH_AFTER, rand_value(), present_key());
      send_cmd(CMD_PUSH_AFTER, rand_value(), absent_key());
      send_cmd(CMD_LIST_ALL, '0, '0);
      send_cmd(CMD_POP_KEY, '0, present_key());
      send_cmd(CMD_POP_FRONT, '0, '0);
      send_cmd(CMD_POP_END, '0, '0);
      send_cmd(CMD_LIST_ALL, '0, '0);
   endtask

   task automatic test_random_traffic();
      int unsigned sent;
      int unsigned grow_pct;
      int unsigned pick;
      logic [CMD_W-1:0] cmd;
      logic [DATA_W-1:0] key;
      sent = 0;
      grow_pct = 50;
      while (sent < 330) begin
         if (sent % 55 == 0) begin
            grow_pct = $urandom_range(20, 85);
            idle_enable = ($urandom_range(0, 3) != 0);
         end
         if (sent % 97 == 96) wait_for_drain();
         pick = $urandom_range(0, 99);
         if (pick < 2) cmd = CMD_RESERVED;
         else if (pick < 9) cmd = CMD_LIST_ALL;
         else if ($urandom_range(0, 99) < grow_pct) cmd = pick_insert();
         else cmd = pick_delete();
         key = ($urandom_range(0, 4) != 0) ? present_key() : rand_value();
         send_cmd(cmd, rand_value(), key);
         if (cmd != CMD_RESERVED) sent++;
      end
      idle_enable = 1'b1;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_empty_list();
      test_basic_edits();
      test_full_list();
      test_random_traffic();
      wait_for_drain();
      repeat (CAPACITY + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_ordered_list_store: clean");
      end else begin
         $display("tb_ordered_list_store: errors");
      end
      $finish;
   end

endmodule
